>>> rtl/core/cpbz_pkg.sv
// Shared types, codes and an arithmetic helper for the Bezier path evaluator.
package cpbz_pkg;

    localparam int COORD_W = 24;
    localparam int U_W     = 17;
    localparam int T_W     = 16;
    localparam int CFG_W   = 7;
    localparam logic [U_W-1:0] U_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_WR_CURVE = 2'd0,
        OP_WR_HIN   = 2'd1,
        OP_WR_HOUT  = 2'd2,
        OP_EVAL     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POS_RANGE = 2'd1,
        ST_IDX_RANGE = 2'd2
    } status_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic    valid;
        logic    is_eval;
        status_t status;
    } ctrl_t;

    function automatic coord_t lerp(input coord_t a, input coord_t b,
                                    input logic [T_W-1:0] t);
        logic signed [COORD_W:0]         diff;
        logic signed [COORD_W+T_W+1:0]   prod;
        logic signed [COORD_W+1:0]       sum;
        begin
            diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
            prod = diff * $signed({1'b0, t});
            sum  = {{2{a[COORD_W-1]}}, a} + prod[T_W +: COORD_W+2];
            lerp = sum[COORD_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/cpbz_lane.sv
// One coordinate lane: three registered rounds of de Casteljau interpolation.
module cpbz_lane (
    input  logic                              aclk,
    input  logic                              en,
    input  cpbz_pkg::coord_t                  p0,
    input  cpbz_pkg::coord_t                  p1,
    input  cpbz_pkg::coord_t                  p2,
    input  cpbz_pkg::coord_t                  p3,
    input  logic [cpbz_pkg::T_W-1:0]          t,
    output cpbz_pkg::coord_t                  res
);

    cpbz_pkg::coord_t q0_reg, q1_reg, q2_reg, r0_reg, r1_reg, res_reg;
    logic [cpbz_pkg::T_W-1:0] t1_reg, t2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q0_reg  <= cpbz_pkg::lerp(p0, p1, t);
            q1_reg  <= cpbz_pkg::lerp(p1, p2, t);
            q2_reg  <= cpbz_pkg::lerp(p2, p3, t);
            t1_reg  <= t;
            r0_reg  <= cpbz_pkg::lerp(q0_reg, q1_reg, t1_reg);
            r1_reg  <= cpbz_pkg::lerp(q1_reg, q2_reg, t1_reg);
            t2_reg  <= t1_reg;
            res_reg <= cpbz_pkg::lerp(r0_reg, r1_reg, t2_reg);
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/core/cpbz_merge.sv
// Output stage: combine lane results with status into the result word.
module cpbz_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  cpbz_pkg::ctrl_t      ctrl,
    input  cpbz_pkg::coord_t     res_x,
    input  cpbz_pkg::coord_t     res_y,
    input  cpbz_pkg::coord_t     res_z,
    output logic                 m_tvalid,
    output logic [79:0]          m_tdata
);

    logic        valid_reg;
    logic [79:0] data_reg;
    logic        keep;

    assign keep = ctrl.is_eval && (ctrl.status == cpbz_pkg::ST_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= {6'd0, ctrl.status,
                         keep ? res_z : '0,
                         keep ? res_y : '0,
                         keep ? res_x : '0};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> rtl/core/cubic_polybezier_point_eval.sv
// Top level of the piecewise cubic Bezier path evaluator.
// Each input word is a store write or an evaluation; every word gives exactly one result
// word, in order, through six register stages, and a new word is taken every cycle unless
// the result side stalls. The input stage computes segment and local t with one small
// multiply, the next stage reads the three point stores (curve store on two ports), then
// one lane per axis runs three registered interpolation rounds, and a merge stage forms
// the result. In-range writes land in the store on the cycle they are accepted.
module cubic_polybezier_point_eval #(
    parameter int MAX_POINTS = 64,
    parameter int DIMENSION  = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // opcode[1:0], point_index[7:2], coord_x[31:8], coord_y[55:32], coord_z[79:56],
    // u_pos[96:80], zero pad
    input  logic [103:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_x[23:0], out_y[47:24], out_z[71:48], status[73:72], zero pad
    output logic [79:0]   m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = (NW > 7) ? NW : 7;
    localparam int DW  = cpbz_pkg::COORD_W * DIMENSION;
    localparam int CRW = cpbz_pkg::COORD_W;

    logic [cpbz_pkg::CFG_W-1:0] num_points_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = {25'd0, num_points_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= 7'd1;
        end else if (cfg_wr) begin
            num_points_reg <= pwdata[6:0];
        end
    end

    logic advance, accept;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    cpbz_pkg::opcode_t          in_op;
    logic [5:0]                 in_idx;
    logic [DW-1:0]              in_pt;
    logic [cpbz_pkg::U_W-1:0]   in_u;
    logic [CW-1:0]              cfg_ext, n_ext;
    logic [NW-1:0]              n_eff;
    logic                       idx_bad, u_bad, pass, in_eval;
    logic [cpbz_pkg::U_W+NW-1:0] prod;

    assign in_op  = cpbz_pkg::opcode_t'(s_tdata[1:0]);
    assign in_idx = s_tdata[7:2];
    assign in_pt  = s_tdata[8 +: DW];
    assign in_u   = s_tdata[96:80];
    assign in_eval = (in_op == cpbz_pkg::OP_EVAL);

    assign cfg_ext = CW'(num_points_reg);
    assign n_ext   = (cfg_ext == '0) ? CW'(1) :
                     (cfg_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cfg_ext;
    assign n_eff   = n_ext[NW-1:0];
    assign idx_bad = (CW'(in_idx) >= n_ext) || (CW'(in_idx) >= CW'(MAX_POINTS));
    assign u_bad   = in_u > cpbz_pkg::U_ONE;
    assign pass    = (in_u == '0) || (n_eff == NW'(1)) || (in_u == cpbz_pkg::U_ONE);
    assign prod    = in_u * (n_eff - NW'(1));

    logic [DW-1:0] curve_mem [MAX_POINTS];
    logic [DW-1:0] hin_mem   [MAX_POINTS];
    logic [DW-1:0] hout_mem  [MAX_POINTS];
    logic [AW-1:0] wr_addr;

    assign wr_addr = AW'(in_idx);

    always_ff @(posedge aclk) begin
        if (accept && !idx_bad) begin
            case (in_op)
                cpbz_pkg::OP_WR_CURVE: curve_mem[wr_addr] <= in_pt;
                cpbz_pkg::OP_WR_HIN:   hin_mem[wr_addr]   <= in_pt;
                cpbz_pkg::OP_WR_HOUT:  hout_mem[wr_addr]  <= in_pt;
                default: ;
            endcase
        end
    end

    cpbz_pkg::ctrl_t ctrl_next;
    cpbz_pkg::ctrl_t ctrl_reg [1:5];
    logic [AW-1:0]   seg1_reg, pass_addr1_reg;
    logic [cpbz_pkg::T_W-1:0] t1_reg, t2_reg;
    logic            pass1_reg, pass2_reg;

    always_comb begin
        ctrl_next.valid   = s_tvalid;
        ctrl_next.is_eval = in_eval;
        if (in_eval) begin
            ctrl_next.status = u_bad ? cpbz_pkg::ST_POS_RANGE : cpbz_pkg::ST_OK;
        end else begin
            ctrl_next.status = idx_bad ? cpbz_pkg::ST_IDX_RANGE : cpbz_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= 5; i++) begin
                ctrl_reg[i] <= '0;
            end
        end else if (advance) begin
            ctrl_reg[1] <= ctrl_next;
            for (int i = 2; i <= 5; i++) begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            seg1_reg       <= prod[cpbz_pkg::T_W +: AW];
            t1_reg         <= prod[cpbz_pkg::T_W-1:0];
            pass1_reg      <= pass;
            pass_addr1_reg <= (in_u == cpbz_pkg::U_ONE) ? AW'(n_eff - NW'(1)) : '0;
        end
    end

    logic [AW-1:0] addr_a, addr_b;
    logic [DW-1:0] ca_reg, cb_reg, ho_reg, hi_reg;

    assign addr_a = pass1_reg ? pass_addr1_reg : seg1_reg;
    assign addr_b = seg1_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (advance) begin
            ca_reg    <= curve_mem[addr_a];
            cb_reg    <= curve_mem[addr_b];
            ho_reg    <= hout_mem[seg1_reg];
            hi_reg    <= hin_mem[addr_b];
            t2_reg    <= t1_reg;
            pass2_reg <= pass1_reg;
        end
    end

    cpbz_pkg::coord_t res [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        if (k < DIMENSION) begin : g_on
            cpbz_pkg::coord_t p0, p1, p2, p3;
            assign p0 = ca_reg[k*CRW +: CRW];
            assign p1 = pass2_reg ? p0 : ho_reg[k*CRW +: CRW];
            assign p2 = pass2_reg ? p0 : hi_reg[k*CRW +: CRW];
            assign p3 = pass2_reg ? p0 : cb_reg[k*CRW +: CRW];
            cpbz_lane u_lane (
                .aclk (aclk),
                .en   (advance),
                .p0   (p0),
                .p1   (p1),
                .p2   (p2),
                .p3   (p3),
                .t    (t2_reg),
                .res  (res[k])
            );
        end else begin : g_off
            assign res[k] = '0;
        end
    end

    cpbz_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .ctrl     (ctrl_reg[5]),
        .res_x    (res[0]),
        .res_y    (res[1]),
        .res_z    (res[2]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/core/cpbz_checker.sv
// Port-level checks for the Bezier path evaluator, bound to the top level.
module cpbz_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[73:72] != 2'd0) |-> (m_tdata[71:0] == 72'd0))
        else $error("error result carries coordinates");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[73:72] != 2'd3) && (m_tdata[79:74] == 6'd0))
        else $error("bad status or padding");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind cubic_polybezier_point_eval cpbz_checker u_cpbz_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/cubic_polybezier_point_eval_tb.sv
// Self-checking bench for the piecewise cubic Bezier path evaluator: stores, segment evaluation, status codes.
module cubic_polybezier_point_eval_tb;

    localparam int NPTS = 64;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [103:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [79:0]   m_tdata;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    typedef struct packed {
        cpbz_pkg::status_t st;
        logic [23:0]       z;
        logic [23:0]       y;
        logic [23:0]       x;
    } point_res_t;

    cpbz_pkg::coord_t curve_m [NPTS][3];
    cpbz_pkg::coord_t hin_m   [NPTS][3];
    cpbz_pkg::coord_t hout_m  [NPTS][3];
    bit     curve_ok [NPTS];
    bit     hin_ok   [NPTS];
    bit     hout_ok  [NPTS];
    logic [6:0] npts_reg;

    point_res_t pending_pts[$];
    int  errors = 0;
    int  cycles = 0;
    int  hold_cnt = 0;
    bit  calm = 1'b0;

    cubic_polybezier_point_eval DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int n_used();
        int n;
        n = int'(npts_reg);
        if (n == 0) n = 1;
        if (n > NPTS) n = NPTS;
        return n;
    endfunction

    function automatic cpbz_pkg::coord_t interp(cpbz_pkg::coord_t a, cpbz_pkg::coord_t b,
                                                logic [15:0] t);
        longint d;
        longint p;
        d = longint'(b) - longint'(a);
        p = d * longint'(t);
        return cpbz_pkg::coord_t'(longint'(a) + (p >>> 16));
    endfunction

    function automatic point_res_t predict_point(logic [1:0] op, logic [5:0] idx,
                                                 cpbz_pkg::coord_t cx, cpbz_pkg::coord_t cy,
                                                 cpbz_pkg::coord_t cz, logic [16:0] u);
        point_res_t r;
        int n;
        int prod;
        int seg;
        logic [15:0] t;
        cpbz_pkg::coord_t p0, p1, p2, p3, q0, q1, q2, r0, r1;
        cpbz_pkg::coord_t v[3];
        r = '0;
        n = n_used();
        if (op != cpbz_pkg::OP_EVAL) begin
            if (idx >= n) begin
                r.st = cpbz_pkg::ST_IDX_RANGE;
                return r;
            end
            case (op)
                cpbz_pkg::OP_WR_CURVE: begin
                    curve_m[idx][0] = cx; curve_m[idx][1] = cy; curve_m[idx][2] = cz;
                    curve_ok[idx] = 1'b1;
                end
                cpbz_pkg::OP_WR_HIN: begin
                    hin_m[idx][0] = cx; hin_m[idx][1] = cy; hin_m[idx][2] = cz;
                    hin_ok[idx] = 1'b1;
                end
                default: begin
                    hout_m[idx][0] = cx; hout_m[idx][1] = cy; hout_m[idx][2] = cz;
                    hout_ok[idx] = 1'b1;
                end
            endcase
            r.st = cpbz_pkg::ST_OK;
            return r;
        end
        if (u > cpbz_pkg::U_ONE) begin
            r.st = cpbz_pkg::ST_POS_RANGE;
            return r;
        end
        r.st = cpbz_pkg::ST_OK;
        if (u == 0 || n == 1) begin
            v = curve_m[0];
        end else if (u == cpbz_pkg::U_ONE) begin
            v = curve_m[n-1];
        end else begin
            prod = int'(u) * (n - 1);
            seg = prod >> 16;
            t = prod[15:0];
            if (seg > n - 2) seg = n - 2;
            for (int k = 0; k < 3; k++) begin
                p0 = curve_m[seg][k];
                p1 = hout_m[seg][k];
                p2 = hin_m[seg+1][k];
                p3 = curve_m[seg+1][k];
                q0 = interp(p0, p1, t);
                q1 = interp(p1, p2, t);
                q2 = interp(p2, p3, t);
                r0 = interp(q0, q1, t);
                r1 = interp(q1, q2, t);
                v[k] = interp(r0, r1, t);
            end
        end
        r.x = v[0]; r.y = v[1]; r.z = v[2];
        return r;
    endfunction

    // Safe to evaluate u: all entries it may read have been written
    function automatic bit eval_safe(logic [16:0] u);
        int n;
        int seg;
        n = n_used();
        if (u > cpbz_pkg::U_ONE) return 1'b1;
        if (u == 0 || n == 1) return curve_ok[0];
        if (u == cpbz_pkg::U_ONE) return curve_ok[n-1];
        seg = (int'(u) * (n - 1)) >> 16;
        if (seg > n - 2) seg = n - 2;
        return curve_ok[seg] && hout_ok[seg] && hin_ok[seg+1] && curve_ok[seg+1];
    endfunction

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic send_word(logic [1:0] op, logic [5:0] idx, cpbz_pkg::coord_t cx,
                             cpbz_pkg::coord_t cy, cpbz_pkg::coord_t cz, logic [16:0] u);
        idle_gap();
        pending_pts = {pending_pts, predict_point(op, idx, cx, cy, cz, u)};
        s_tdata  <= {7'd0, u, cz, cy, cx, idx, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_npts(logic [31:0] val);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        npts_reg = val[6:0];
    endtask

    function automatic cpbz_pkg::coord_t rnd_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return cpbz_pkg::coord_t'($urandom);
        endcase
    endfunction

    task automatic load_path(int n);
        for (int i = 0; i < n; i++) begin
            send_word(cpbz_pkg::OP_WR_CURVE, 6'(i), rnd_coord(), rnd_coord(), rnd_coord(),
                      17'($urandom));
            send_word(cpbz_pkg::OP_WR_HIN, 6'(i), rnd_coord(), rnd_coord(), rnd_coord(),
                      17'($urandom));
            send_word(cpbz_pkg::OP_WR_HOUT, 6'(i), rnd_coord(), rnd_coord(), rnd_coord(),
                      17'($urandom));
        end
    endtask

    task automatic test_directed();
        write_npts(32'd4);
        load_path(4);
        send_word(cpbz_pkg::OP_EVAL, 6'h3F, '0, '0, '0, 17'd0);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, cpbz_pkg::U_ONE);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, 17'h10001);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, 17'h1FFFF);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, 17'h0FFFF);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, 17'h08000);
        send_word(cpbz_pkg::OP_WR_CURVE, 6'h3F, 24'sh7FFFFF, 24'sh800000, '0, '0);
        send_word(cpbz_pkg::OP_WR_HOUT, 6'd4, '1, '1, '1, '0);
        write_npts(32'd1);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, 17'h04321);
        send_word(cpbz_pkg::OP_WR_HIN, 6'd1, '0, '0, '0, '0);
        write_npts(32'd0);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, 17'h0ABCD);
        write_npts(32'h7F);
        send_word(cpbz_pkg::OP_WR_CURVE, 6'h3F, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, '0);
        send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, cpbz_pkg::U_ONE);
    endtask

    task automatic test_random_paths(int words);
        int n;
        int cnt;
        logic [16:0] u;
        cnt = 0;
        while (cnt < words) begin
            n = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(2, 8);
            write_npts(n);
            load_path(n);
            cnt += 3 * n;
            repeat ($urandom_range(20, 60)) begin
                case ($urandom_range(0, 9))
                    0: u = 17'(17'h10000 + $urandom_range(1, 65535));
                    1: u = cpbz_pkg::U_ONE;
                    2: u = '0;
                    default: u = 17'($urandom_range(1, 65535));
                endcase
                if ($urandom_range(0, 7) == 0)
                    send_word(2'($urandom_range(0, 2)), 6'($urandom), rnd_coord(),
                              rnd_coord(), rnd_coord(), 17'($urandom));
                else if (eval_safe(u))
                    send_word(cpbz_pkg::OP_EVAL, 6'($urandom),
                              cpbz_pkg::coord_t'($urandom), cpbz_pkg::coord_t'($urandom),
                              cpbz_pkg::coord_t'($urandom), u);
                cnt++;
            end
        end
    endtask

    task automatic test_full_rate();
        logic [16:0] u;
        calm = 1'b1;
        write_npts(32'd5);
        load_path(5);
        repeat (80) begin
            u = 17'($urandom_range(0, 65536));
            if (eval_safe(u)) send_word(cpbz_pkg::OP_EVAL, 6'd0, '0, '0, '0, u);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            hold_cnt <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        point_res_t want;
        point_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[73:0];
            if (pending_pts.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = pending_pts.pop_front();
                if (got.x !== want.x) begin
                    $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y) begin
                    $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
                    errors++;
                end
                if (got.z !== want.z) begin
                    $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
                    errors++;
                end
                if (got.st !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NPTS; i++) begin
            curve_ok[i] = 0; hin_ok[i] = 0; hout_ok[i] = 0;
            for (int k = 0; k < 3; k++) begin
                curve_m[i][k] = 0; hin_m[i][k] = 0; hout_m[i][k] = 0;
            end
        end
        npts_reg = 7'd1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_paths(560);
        test_full_rate();
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
